>>> src/tepdr_pkg.sv
// Shared types, codes and reset values for the touch press/drag/release decoder.
package tepdr_pkg;

	localparam int unsigned COORD_W    = 16;
	localparam int unsigned PROD_W     = 2 * COORD_W;
	localparam int unsigned CFG_IDX_W  = 3;

	// Event kinds
	localparam logic [1:0] FUNC_KEY  = 2'd0;
	localparam logic [1:0] FUNC_X    = 2'd1;
	localparam logic [1:0] FUNC_Y    = 2'd2;
	localparam logic [1:0] FUNC_SYNC = 2'd3;

	// Gesture codes
	localparam logic [1:0] GST_PRESS   = 2'd0;
	localparam logic [1:0] GST_DRAG    = 2'd1;
	localparam logic [1:0] GST_RELEASE = 2'd2;
	localparam logic [1:0] GST_NONE    = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_TURNS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_X_MINIMUM     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_X_SPAN        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_MINIMUM     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_SPAN        = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_DRAG_ENABLE   = 3'd7;

	localparam logic [COORD_W-1:0] RST_SCREEN_WIDTH  = 16'd800;
	localparam logic [COORD_W-1:0] RST_SCREEN_HEIGHT = 16'd480;
	localparam logic [COORD_W-1:0] RST_SPAN          = 16'd4095;

	typedef struct packed {
		logic [1:0]         func;
		logic [COORD_W-1:0] value;
	} evt_t;

	typedef struct packed {
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [1:0]         gesture;
	} gst_t;

	typedef struct packed {
		logic               start;
		logic [PROD_W-1:0]  dividend;
		logic [COORD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> src/touch_event_press_drag_release.sv
// Touch event decoder: scales raw positions, rotates on sync, reports press/drag/release.
// Key events are taken at accept; a frame sync moves to the sync state, which loads any
// result; raw X/Y pass accept, offset, multiply, divider load, 32 steps of the shared
// restoring divider, and write-back. One item at a time: ready only in the idle state.
// A sync that reports a gesture waits while the output register still holds an untaken item.
// Reset (arst_n low, asynchronous): registers to their defaults, all touch state cleared.
module touch_event_press_drag_release
	import tepdr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 evt_valid,
	output logic                 evt_ready,
	input  evt_t                 evt,
	output logic                 gst_valid,
	input  logic                 gst_ready,
	output gst_t                 gst,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIFF,
		S_MUL,
		S_LOAD,
		S_DIV,
		S_SYNC
	} state_t;

	state_t state_q;

	// Configuration
	logic [COORD_W-1:0] width_q, height_q, x_min_q, x_span_q, y_min_q, y_span_q;
	logic [1:0]         turns_q;
	logic               drag_en_q;

	// Touch state
	logic [COORD_W-1:0] scaled_x_q, scaled_y_q, rotated_x_q, rotated_y_q;
	logic               touching_q, edge_pend_q, coords_pend_q, pressed_q;

	// Output register
	logic gst_valid_q;
	gst_t gst_q;

	// Scaling datapath
	logic [COORD_W-1:0] raw_q;
	logic               axis_y_q;
	logic [COORD_W-1:0] mag_q;
	logic               neg_q;
	logic [PROD_W-1:0]  prod_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic               accept;
	logic [COORD_W:0]   diff;
	logic [COORD_W-1:0] size, minimum, span, q16, scaled_new;
	logic [COORD_W-1:0] rot_x, rot_y, out_x, out_y, wm1, hm1;
	logic               emit, out_free, sync_go, gst_load;
	logic [1:0]         gesture;

	assign evt_ready = (state_q == S_IDLE);
	assign accept    = evt_valid && evt_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !gst_valid_q || gst_ready;
	assign sync_go   = !emit || out_free;
	assign gst_load  = (state_q == S_SYNC) && emit && out_free;

	always_comb begin
		size    = axis_y_q ? height_q : width_q;
		minimum = axis_y_q ? y_min_q : x_min_q;
		span    = axis_y_q ? y_span_q : x_span_q;
		diff    = {1'b0, raw_q} - {1'b0, minimum};
		q16     = div_rsp.quotient[COORD_W-1:0];
		scaled_new = neg_q ? (COORD_W'(0) - q16) : q16;

		div_req.start    = (state_q == S_LOAD);
		div_req.dividend = prod_q;
		div_req.divisor  = (span == '0) ? COORD_W'(1) : span;
	end

	// Rotation and gesture decision for a frame sync
	always_comb begin
		wm1 = width_q - 1'b1;
		hm1 = height_q - 1'b1;
		unique case (turns_q)
			2'd1: begin
				rot_x = scaled_y_q;
				rot_y = wm1 - scaled_x_q;
			end
			2'd2: begin
				rot_x = wm1 - scaled_x_q;
				rot_y = hm1 - scaled_y_q;
			end
			2'd3: begin
				rot_x = hm1 - scaled_y_q;
				rot_y = scaled_x_q;
			end
			default: begin
				rot_x = scaled_x_q;
				rot_y = scaled_y_q;
			end
		endcase
		out_x = coords_pend_q ? rot_x : rotated_x_q;
		out_y = coords_pend_q ? rot_y : rotated_y_q;

		emit    = 1'b0;
		gesture = GST_NONE;
		if (touching_q && (coords_pend_q || edge_pend_q)) begin
			if (!pressed_q) begin
				emit    = 1'b1;
				gesture = GST_PRESS;
			end else if (drag_en_q && coords_pend_q) begin
				emit    = 1'b1;
				gesture = GST_DRAG;
			end
		end else if (!touching_q && edge_pend_q) begin
			emit    = 1'b1;
			gesture = GST_RELEASE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			width_q       <= RST_SCREEN_WIDTH;
			height_q      <= RST_SCREEN_HEIGHT;
			turns_q       <= '0;
			x_min_q       <= '0;
			x_span_q      <= RST_SPAN;
			y_min_q       <= '0;
			y_span_q      <= RST_SPAN;
			drag_en_q     <= 1'b0;
			scaled_x_q    <= '0;
			scaled_y_q    <= '0;
			rotated_x_q   <= '0;
			rotated_y_q   <= '0;
			touching_q    <= 1'b0;
			edge_pend_q   <= 1'b0;
			coords_pend_q <= 1'b0;
			pressed_q     <= 1'b0;
			gst_valid_q   <= 1'b0;
			gst_q         <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_SCREEN_WIDTH:  width_q   <= cfg_data;
					CFG_SCREEN_HEIGHT: height_q  <= cfg_data;
					CFG_QUARTER_TURNS: turns_q   <= cfg_data[1:0];
					CFG_X_MINIMUM:     x_min_q   <= cfg_data;
					CFG_X_SPAN:        x_span_q  <= cfg_data;
					CFG_Y_MINIMUM:     y_min_q   <= cfg_data;
					CFG_Y_SPAN:        y_span_q  <= cfg_data;
					CFG_DRAG_ENABLE:   drag_en_q <= cfg_data[0];
					default: ;
				endcase
			end

			// load a new gesture, else drop the taken one
			if (gst_load) begin
				gst_valid_q <= 1'b1;
			end else if (gst_ready) begin
				gst_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (evt.func)
							FUNC_KEY: begin
								if (evt.value == COORD_W'(1)) begin
									touching_q  <= 1'b1;
									edge_pend_q <= 1'b1;
									pressed_q   <= 1'b0;
								end else if (evt.value == '0) begin
									touching_q  <= 1'b0;
									edge_pend_q <= 1'b1;
								end
							end
							FUNC_X, FUNC_Y: begin
								// drop zero positions
								if (evt.value != '0) begin
									state_q <= S_DIFF;
								end
							end
							default: state_q <= S_SYNC;
						endcase
					end
				end
				S_DIFF: state_q <= S_MUL;
				S_MUL:  state_q <= S_LOAD;
				S_LOAD: state_q <= S_DIV;
				S_DIV: begin
					if (div_rsp.done) begin
						if (axis_y_q) begin
							scaled_y_q <= scaled_new;
						end else begin
							scaled_x_q <= scaled_new;
						end
						coords_pend_q <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				S_SYNC: begin
					// hold while a gesture cannot be placed in the output register
					if (sync_go) begin
						if (coords_pend_q) begin
							rotated_x_q <= rot_x;
							rotated_y_q <= rot_y;
						end
						if (emit) begin
							gst_q.pos_x   <= out_x;
							gst_q.pos_y   <= out_y;
							gst_q.gesture <= gesture;
						end
						if (emit && gesture == GST_PRESS) begin
							pressed_q <= 1'b1;
						end
						edge_pend_q   <= 1'b0;
						coords_pend_q <= 1'b0;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_q    <= evt.value;
			axis_y_q <= (evt.func == FUNC_Y);
		end
		if (state_q == S_DIFF) begin
			neg_q <= diff[COORD_W];
			mag_q <= diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
		end
		if (state_q == S_MUL) begin
			prod_q <= PROD_W'(size) * PROD_W'(mag_q);
		end
	end

	tepdr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign gst_valid = gst_valid_q;
	assign gst       = gst_q;

endmodule

>>> src/tepdr_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit dividend over 16-bit divisor.
module tepdr_div
	import tepdr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int unsigned CNT_W = $clog2(PROD_W);

	logic [COORD_W-1:0] rem_q;
	logic [COORD_W-1:0] den_q;
	logic [PROD_W-1:0]  quot_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [COORD_W:0] rem_sh;
	logic             ge;
	logic [COORD_W:0] rem_sub;

	always_comb begin
		rem_sh  = {rem_q, quot_q[PROD_W-1]};
		ge      = (rem_sh >= {1'b0, den_q});
		rem_sub = rem_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(PROD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			den_q  <= req.divisor;
			quot_q <= req.dividend;
		end else if (busy_q) begin
			rem_q  <= ge ? rem_sub[COORD_W-1:0] : rem_sh[COORD_W-1:0];
			quot_q <= {quot_q[PROD_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quot_q;

endmodule

>>> src/tepdr_checker.sv
// Port-level checks for the touch decoder, bound to the top level.
module tepdr_checker
	import tepdr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic evt_valid,
	input logic evt_ready,
	input evt_t evt,
	input logic gst_valid,
	input logic gst_ready,
	input gst_t gst
);

	// hold a stalled result
	a_gst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		gst_valid && !gst_ready |=> gst_valid && $stable(gst))
		else $error("result changed or dropped while stalled");

	a_gst_code: assert property (@(posedge clk) disable iff (!arst_n)
		gst_valid |-> gst.gesture != GST_NONE)
		else $error("unused gesture code shown");

	a_no_result_non_sync: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready && evt.func != FUNC_SYNC |=> !$rose(gst_valid))
		else $error("result raised by an item other than a frame sync");

	a_pos_busy: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready && (evt.func == FUNC_X || evt.func == FUNC_Y)
		&& evt.value != '0 |=> !evt_ready)
		else $error("ready during scaling");

	a_sync_busy: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready && evt.func == FUNC_SYNC |=> !evt_ready)
		else $error("ready right after a frame sync");

endmodule

bind touch_event_press_drag_release tepdr_checker u_tepdr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.evt_valid (evt_valid),
	.evt_ready (evt_ready),
	.evt       (evt),
	.gst_valid (gst_valid),
	.gst_ready (gst_ready),
	.gst       (gst)
);
